// ===== src/iaf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrate-and-fire embedding package
// Shared sizes, request type and fixed-point helpers.
// ----------------------------------------------------------------------------
package iaf_pkg;

    localparam int MAX_DIM = 512;
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int CFG_W   = 10;
    localparam int ACT_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int VAL_W   = 16;
    localparam int WGT_W   = 16;
    localparam int EMB_W   = 24;
    localparam int PRD_W   = 18;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(512);
    localparam logic [WGT_W-1:0] ONE_Q15   = 16'h8000;

    localparam logic signed [EMB_W-1:0] EMB_MAX = {1'b0, {(EMB_W-1){1'b1}}};
    localparam logic signed [EMB_W-1:0] EMB_MIN = {1'b1, {(EMB_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic [IDX_W-1:0]        idx;
        logic                    zero_rd;
        logic                    fires;
        logic [WGT_W-1:0]        remain;
        logic [WGT_W-1:0]        carry;
        logic                    last;
    } t_s0_req;

    // Q4.11 times Q1.15, rounded half up to Q.11
    function automatic logic signed [PRD_W-1:0] weigh(
        input logic signed [VAL_W-1:0] x,
        input logic [WGT_W-1:0]        w
    );
        logic signed [VAL_W+WGT_W:0] p;
        p = (VAL_W+WGT_W+1)'(x) * $signed({1'b0, w}) + (VAL_W+WGT_W+1)'(16384);
        return p[VAL_W+WGT_W:15];
    endfunction

    function automatic logic signed [EMB_W-1:0] sat_emb(
        input logic signed [EMB_W:0] v
    );
        logic signed [EMB_W-1:0] r;
        if (v[EMB_W] != v[EMB_W-1]) begin
            r = v[EMB_W] ? EMB_MIN : EMB_MAX;
        end else begin
            r = v[EMB_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/iaf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrate-and-fire request control
// Dimension register, element index, running weight total and fill count;
// builds the per-element request for the datapath.
// ----------------------------------------------------------------------------
module iaf_ctrl
    import iaf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_accept,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic [WGT_W-1:0]        i_frame_weight,
    input  logic                    i_utterance_start,
    output t_s0_req                 o_req
);

    logic [CFG_W-1:0] r_dim_cfg;
    logic [IDX_W-1:0] r_elem_idx, n_elem_idx;
    logic [WGT_W-1:0] r_total, n_total;
    logic             r_fires, n_fires;
    logic [WGT_W-1:0] r_remain, n_remain;
    logic [WGT_W-1:0] r_carry, n_carry;
    logic [CNT_W-1:0] r_fill, n_fill;

    logic [ACT_W-1:0] cfg_ext;
    logic [CNT_W-1:0] dim;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] idx_inc;
    logic [IDX_W-1:0] idx_cur;
    logic [WGT_W-1:0] w_clamp;
    logic [WGT_W:0]   acc;
    logic [WGT_W:0]   over;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        cfg_ext = ACT_W'(r_dim_cfg);
        if (cfg_ext == '0) begin
            dim = CNT_W'(1);
        end else if (cfg_ext > ACT_W'(MAX_DIM)) begin
            dim = CNT_W'(MAX_DIM);
        end else begin
            dim = CNT_W'(cfg_ext);
        end
    end

    always_comb begin
        if (CNT_W'(r_elem_idx) >= dim) begin
            idx_cur = '0;
        end else begin
            idx_cur = r_elem_idx;
        end
        idx_ext = CNT_W'(idx_cur);
        idx_inc = idx_ext + CNT_W'(1);
        if (idx_inc >= dim) begin
            n_elem_idx = '0;
        end else begin
            n_elem_idx = idx_inc[IDX_W-1:0];
        end
    end

    always_comb begin
        w_clamp = (i_frame_weight > ONE_Q15) ? ONE_Q15 : i_frame_weight;
        acc     = {1'b0, (i_utterance_start ? {WGT_W{1'b0}} : r_total)} + {1'b0, w_clamp};
        over    = acc - {1'b0, ONE_Q15};
        n_fires  = r_fires;
        n_remain = r_remain;
        n_carry  = r_carry;
        n_total  = r_total;
        if (idx_cur == '0) begin
            if (acc >= {1'b0, ONE_Q15}) begin
                n_fires  = 1'b1;
                n_remain = w_clamp - over[WGT_W-1:0];
                n_carry  = over[WGT_W-1:0];
                n_total  = over[WGT_W-1:0];
            end else begin
                n_fires  = 1'b0;
                n_remain = w_clamp;
                n_carry  = '0;
                n_total  = acc[WGT_W-1:0];
            end
        end
        n_fill = (idx_ext == r_fill) ? r_fill + CNT_W'(1) : r_fill;
    end

    always_comb begin
        o_req.x       = i_sample_value;
        o_req.idx     = idx_cur;
        o_req.zero_rd = i_utterance_start || (idx_ext >= r_fill);
        o_req.fires   = n_fires;
        o_req.remain  = n_remain;
        o_req.carry   = n_carry;
        o_req.last    = (idx_inc == dim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_cfg  <= DIM_RESET;
            r_elem_idx <= '0;
            r_total    <= '0;
            r_fires    <= 1'b0;
            r_remain   <= '0;
            r_carry    <= '0;
            r_fill     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_dim_cfg <= i_cfg_data;
            end
            if (i_accept) begin
                r_elem_idx <= n_elem_idx;
                r_total    <= n_total;
                r_fires    <= n_fires;
                r_remain   <= n_remain;
                r_carry    <= n_carry;
                r_fill     <= n_fill;
            end
        end
    end

    a_total_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_total[WGT_W-1])
        else $error("weight total reached one");

    a_carry_only_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_carry != '0) |-> r_fires)
        else $error("carry weight without firing frame");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_DIM))
        else $error("fill count past store depth");

endmodule

// ===== src/iaf_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrate-and-fire datapath
// Embedding store, weighted accumulate stage and output register.
// ----------------------------------------------------------------------------
module iaf_dpath
    import iaf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_stall,
    input  t_s0_req                 i_req,
    output logic                    o_accept,
    output logic                    o_adv,
    output logic                    o_valid,
    output logic signed [EMB_W-1:0] o_embed_value,
    output logic                    o_token_last
);

    logic signed [EMB_W-1:0] mem [MAX_DIM];

    logic                    r_s1_valid;
    t_s0_req                 r_s1;
    logic signed [EMB_W-1:0] r_rdata;
    logic                    r_fwd;
    logic signed [EMB_W-1:0] r_fwd_data;
    logic                    r_out_valid;
    logic signed [EMB_W-1:0] r_out_data;
    logic                    r_out_last;

    logic signed [EMB_W-1:0] stored;
    logic signed [PRD_W-1:0] w_rem;
    logic signed [PRD_W-1:0] w_car;
    logic signed [EMB_W:0]   sum;
    logic signed [EMB_W-1:0] sum_sat;
    logic signed [EMB_W-1:0] wdata;
    logic                    wr_en;

    assign o_adv    = !(r_out_valid && i_stall);
    assign o_accept = i_valid && o_adv;
    assign wr_en    = o_adv && r_s1_valid;

    always_comb begin
        if (r_s1.zero_rd) begin
            stored = '0;
        end else begin
            stored = r_fwd ? r_fwd_data : r_rdata;
        end
        w_rem   = weigh(r_s1.x, r_s1.remain);
        w_car   = weigh(r_s1.x, r_s1.carry);
        sum     = (EMB_W+1)'(stored) + (EMB_W+1)'(w_rem);
        sum_sat = sat_emb(sum);
        wdata   = r_s1.fires ? EMB_W'(w_car) : sum_sat;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1.idx] <= wdata;
        end
        if (o_accept) begin
            r_rdata <= mem[i_req.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            if (o_adv) begin
                r_s1_valid  <= o_accept;
                r_out_valid <= r_s1_valid && r_s1.fires;
            end
            if (o_accept) begin
                r_fwd <= wr_en && (r_s1.idx == i_req.idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_s1       <= i_req;
            r_fwd_data <= wdata;
        end
        if (wr_en && r_s1.fires) begin
            r_out_data <= sum_sat;
            r_out_last <= r_s1.last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_embed_value = r_out_data;
    assign o_token_last  = r_out_last;

    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd) |-> $past(wr_en))
        else $error("bypass set without store write");

    a_out_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1.fires))
        else $error("result without firing element");

    a_s1_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s1_valid) |-> $past(o_accept))
        else $error("stage valid without accepted request");

endmodule

// ===== src/integrate_and_fire_embedding.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrate-and-fire token embedding
// Fired elements pass the stage and output registers. Throughput: one
// element per cycle unless stalled; the store read-modify-write per element
// and the output register set the pace, with a bypass for back-to-back
// reuse. Reset: synchronous active low; clears index, weight total, fill
// count and valids; store entries read as zero until written.
// ----------------------------------------------------------------------------
module integrate_and_fire_embedding
    import iaf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic [WGT_W-1:0]        i_frame_weight,
    input  logic                    i_utterance_start,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [EMB_W-1:0] o_embed_value,
    output logic                    o_token_last,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    t_s0_req req;
    logic    accept;
    logic    adv;

    iaf_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_accept          (accept),
        .i_sample_value    (i_sample_value),
        .i_frame_weight    (i_frame_weight),
        .i_utterance_start (i_utterance_start),
        .o_req             (req)
    );

    iaf_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_stall       (i_stall),
        .i_req         (req),
        .o_accept      (accept),
        .o_adv         (adv),
        .o_valid       (o_valid),
        .o_embed_value (o_embed_value),
        .o_token_last  (o_token_last)
    );

    assign o_stall = !adv;

endmodule
